@@ hdl/ess_pkg.sv @@
// ----------------------------------------------------------------------------
// Sweep generator package
// Shared widths, codes, register defaults and the quarter-wave sine builder.
// ----------------------------------------------------------------------------
package ess_pkg;

  localparam int unsigned ESS_SINE_TABLE_DEPTH = 1024;
  localparam int unsigned ESS_SAMPLE_WIDTH     = 16;
  localparam int unsigned ESS_PHASE_WIDTH      = 32;
  localparam int unsigned ESS_QUEUE_DEPTH      = 2;

  localparam int unsigned ESS_INC_W      = 32;
  localparam int unsigned ESS_DLY_W      = 24;
  localparam int unsigned ESS_LEN_W      = 20;
  localparam int unsigned ESS_AMP_W      = 16;
  localparam int unsigned ESS_GAIN_W     = 17;
  localparam int unsigned ESS_GAIN_FRAC  = 16;
  localparam int unsigned ESS_STAGE_W    = 3;
  localparam int unsigned ESS_CFG_IDX_W  = 3;
  localparam int unsigned ESS_CFG_DATA_W = 32;
  localparam int unsigned ESS_STEP_FRAC  = 30;
  localparam int unsigned ESS_MAG_SHIFT  = 31;
  localparam int unsigned ESS_DIV_CNT_W  = 5;

  localparam logic [ESS_AMP_W-1:0]  ESS_AMP_FULL   = 16'h8000;
  localparam logic [ESS_GAIN_W-1:0] ESS_UNITY_GAIN = 17'h10000;
  localparam logic [63:0]           ESS_INC_ROUND  = 64'h0000_0000_2000_0000;
  localparam logic [63:0]           ESS_MAG_ROUND  = 64'h0000_0000_4000_0000;

  localparam longint ESS_Q30         = 64'd1073741824;
  localparam longint ESS_HALF_PI_Q30 = 64'd1686629713;
  localparam longint ESS_TAYLOR_DIV [9] = '{6, 20, 42, 72, 110, 156, 210, 272, 342};

  typedef enum logic [ESS_STAGE_W-1:0] {
    ST_DELAY    = 3'd0,
    ST_FADE_IN  = 3'd1,
    ST_SWEEP    = 3'd2,
    ST_FADE_OUT = 3'd3,
    ST_FINISHED = 3'd4
  } stage_e;

  typedef enum logic [ESS_CFG_IDX_W-1:0] {
    CFG_START_INC    = 3'd0,
    CFG_FINAL_INC    = 3'd1,
    CFG_STEP_MUL     = 3'd2,
    CFG_DELAY_LEN    = 3'd3,
    CFG_FADE_IN_LEN  = 3'd4,
    CFG_FADE_OUT_LEN = 3'd5,
    CFG_AMPLITUDE    = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_UPD
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_LOOK,
    B_DIV,
    B_SQR,
    B_MAG1,
    B_MAG2,
    B_EMIT
  } back_state_e;

  typedef struct packed {
    logic [ESS_INC_W-1:0] start_inc;
    logic [ESS_INC_W-1:0] final_inc;
    logic [ESS_INC_W-1:0] step_mul;
    logic [ESS_DLY_W-1:0] delay_len;
    logic [ESS_LEN_W-1:0] fade_in_len;
    logic [ESS_LEN_W-1:0] fade_out_len;
    logic [ESS_AMP_W-1:0] amplitude;
  } ess_cfg_t;

  localparam ess_cfg_t ESS_CFG_RESET = '{
    start_inc:    32'd1610613,
    final_inc:    32'd1968526677,
    step_mul:     32'd1073821334,
    delay_len:    24'd0,
    fade_in_len:  20'd0,
    fade_out_len: 20'd0,
    amplitude:    16'd16384
  };

  typedef struct packed {
    stage_e               stage;
    logic [ESS_LEN_W-1:0] num;
    logic [ESS_LEN_W-1:0] len;
  } ess_job_t;

  // One quarter-wave entry from a Q30 angle, by a ten-term Taylor series.
  function automatic longint ess_sine_entry(input longint x, input longint peak);
    longint sum;
    longint t;
    longint v;
    sum = x;
    t   = x;
    for (int n = 0; n < 9; n++) begin
      t   = t * x / ESS_Q30;
      t   = t * x / ESS_Q30;
      t   = -t / ESS_TAYLOR_DIV[n];
      sum = sum + t;
    end
    if (sum < 0) sum = 0;
    v = (sum * peak + ESS_Q30 / 2) / ESS_Q30;
    if (v > peak) v = peak;
    return v;
  endfunction

endpackage

@@ hdl/ess_if.sv @@
// ----------------------------------------------------------------------------
// Sweep generator channels
// Tick request channel and sample result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ess_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface ess_out_if import ess_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = ESS_SAMPLE_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic [ESS_STAGE_W-1:0]        stage;
  logic                          finished;

  modport source (output valid, output sample, output stage, output finished, input ready);
  modport sink   (input valid, input sample, input stage, input finished, output ready);
endinterface

@@ hdl/ess_queue.sv @@
// ----------------------------------------------------------------------------
// Sweep generator job queue
// Small flip-flop FIFO between the sequencer and the sample datapath.
// ----------------------------------------------------------------------------
module ess_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ hdl/ess_front.sv @@
// ----------------------------------------------------------------------------
// Sweep generator sequencer
// Takes ticks, steps the stage counters, phase and increment, and queues
// one sample job per tick.
// ----------------------------------------------------------------------------
module ess_front import ess_pkg::*; #(
  parameter int unsigned SINE_TABLE_DEPTH = ESS_SINE_TABLE_DEPTH,
  parameter int unsigned PHASE_WIDTH      = ESS_PHASE_WIDTH,
  localparam int unsigned AddrW = $clog2(SINE_TABLE_DEPTH) + 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ess_cfg_t         cfg_i,
  ess_in_if.sink           in_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output ess_job_t         q_job_o,
  output logic [AddrW-1:0] q_phase_o
);

  front_state_e           state_q, state_d;
  stage_e                 stage_q, stage_d;
  logic [PHASE_WIDTH-1:0] phase_q, phase_d;
  logic [ESS_INC_W-1:0]   inc_q, inc_d;
  logic [ESS_DLY_W-1:0]   dly_q, dly_d;
  logic [ESS_LEN_W-1:0]   fin_q, fin_d;
  logic [ESS_LEN_W-1:0]   fout_q, fout_d;
  logic [63:0]            prod_q, prod_d;

  logic                   accept;
  stage_e                 eff_stage;
  logic [PHASE_WIDTH-1:0] eff_phase;
  logic [PHASE_WIDTH-1:0] next_phase;
  logic [ESS_INC_W-1:0]   eff_inc;
  logic [ESS_DLY_W-1:0]   eff_dly;
  logic [ESS_LEN_W-1:0]   eff_fin, eff_fout;
  logic [ESS_LEN_W-1:0]   fin_clip, fout_clip;
  logic [63:0]            prod_rnd;
  logic [ESS_INC_W+1:0]   inc_rnd;
  logic [ESS_INC_W-1:0]   inc_sat;

  assign in_i.ready = (state_q == F_IDLE) && !q_full_i;
  assign accept     = in_i.valid && in_i.ready;

  assign eff_stage  = in_i.restart ? ST_DELAY : stage_q;
  assign eff_phase  = in_i.restart ? '0 : phase_q;
  assign eff_inc    = in_i.restart ? cfg_i.start_inc : inc_q;
  assign eff_dly    = in_i.restart ? cfg_i.delay_len : dly_q;
  assign eff_fin    = in_i.restart ? cfg_i.fade_in_len : fin_q;
  assign eff_fout   = in_i.restart ? cfg_i.fade_out_len : fout_q;
  assign next_phase = eff_phase + PHASE_WIDTH'(eff_inc);

  assign fin_clip  = (eff_fin > cfg_i.fade_in_len) ? cfg_i.fade_in_len : eff_fin;
  assign fout_clip = (eff_fout > cfg_i.fade_out_len) ? cfg_i.fade_out_len : eff_fout;

  assign prod_d   = 64'(inc_q) * 64'(cfg_i.step_mul);
  assign prod_rnd = prod_q + ESS_INC_ROUND;
  assign inc_rnd  = prod_rnd[ESS_STEP_FRAC +: ESS_INC_W + 2];
  assign inc_sat  = (inc_rnd[ESS_INC_W +: 2] != 2'b00) ? '1 : inc_rnd[ESS_INC_W-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: begin
        if (accept && (eff_stage == ST_SWEEP)) state_d = F_MUL;
      end
      F_MUL:   state_d = F_UPD;
      F_UPD:   state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    stage_d   = stage_q;
    phase_d   = phase_q;
    inc_d     = inc_q;
    dly_d     = dly_q;
    fin_d     = fin_q;
    fout_d    = fout_q;
    q_push_o  = accept;
    q_job_o   = '{stage: eff_stage, num: '0, len: '0};
    q_phase_o = eff_phase[PHASE_WIDTH-1 -: AddrW];
    if (state_q == F_UPD) begin
      inc_d = inc_sat;
      if (inc_sat >= cfg_i.final_inc) stage_d = ST_FADE_OUT;
    end
    if (accept) begin
      stage_d = eff_stage;
      phase_d = eff_phase;
      inc_d   = eff_inc;
      dly_d   = eff_dly;
      fin_d   = eff_fin;
      fout_d  = eff_fout;
      unique case (eff_stage)
        ST_DELAY: begin
          dly_d = (eff_dly == '0) ? '0 : eff_dly - ESS_DLY_W'(1);
          if (eff_dly <= ESS_DLY_W'(1)) stage_d = ST_FADE_IN;
        end
        ST_FADE_IN: begin
          q_job_o.num = cfg_i.fade_in_len - fin_clip;
          q_job_o.len = cfg_i.fade_in_len;
          phase_d     = next_phase;
          fin_d       = (eff_fin == '0) ? '0 : eff_fin - ESS_LEN_W'(1);
          if (eff_fin <= ESS_LEN_W'(1)) stage_d = ST_SWEEP;
        end
        ST_SWEEP: begin
          phase_d = next_phase;
        end
        ST_FADE_OUT: begin
          q_job_o.num = fout_clip;
          q_job_o.len = cfg_i.fade_out_len;
          phase_d     = next_phase;
          fout_d      = (eff_fout == '0) ? '0 : eff_fout - ESS_LEN_W'(1);
          if (eff_fout <= ESS_LEN_W'(1)) stage_d = ST_FINISHED;
        end
        default: begin
          q_job_o.stage = ST_FINISHED;
          stage_d       = ST_FINISHED;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      stage_q <= ST_DELAY;
      phase_q <= '0;
      inc_q   <= ESS_CFG_RESET.start_inc;
      dly_q   <= ESS_CFG_RESET.delay_len;
      fin_q   <= ESS_CFG_RESET.fade_in_len;
      fout_q  <= ESS_CFG_RESET.fade_out_len;
    end else begin
      state_q <= state_d;
      stage_q <= stage_d;
      phase_q <= phase_d;
      inc_q   <= inc_d;
      dly_q   <= dly_d;
      fin_q   <= fin_d;
      fout_q  <= fout_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_MUL) begin
      prod_q <= prod_d;
    end
  end

endmodule

@@ hdl/ess_back.sv @@
// ----------------------------------------------------------------------------
// Sweep generator sample datapath
// Fade gain divider and squarer, quarter-wave sine lookup, amplitude and
// gain scaling with rounding, and the output register.
// ----------------------------------------------------------------------------
module ess_back import ess_pkg::*; #(
  parameter int unsigned SINE_TABLE_DEPTH = ESS_SINE_TABLE_DEPTH,
  parameter int unsigned SAMPLE_WIDTH     = ESS_SAMPLE_WIDTH,
  localparam int unsigned TabW  = $clog2(SINE_TABLE_DEPTH),
  localparam int unsigned AddrW = TabW + 2,
  localparam int unsigned IdxW  = TabW + 1,
  localparam int unsigned MagW  = SAMPLE_WIDTH - 1,
  localparam int unsigned SaW   = MagW + ESS_AMP_W,
  localparam int unsigned ProdW = SaW + ESS_GAIN_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [ESS_AMP_W-1:0] amplitude_i,
  input  logic                 q_empty_i,
  output logic                 q_pop_o,
  input  ess_job_t             q_job_i,
  input  logic [AddrW-1:0]     q_phase_i,
  ess_out_if.source            out_o
);

  localparam longint Peak = (longint'(1) << MagW) - 1;

  logic [MagW-1:0] rom [SINE_TABLE_DEPTH + 1];

  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam longint X =
      (longint'(k) * ESS_HALF_PI_Q30 + SINE_TABLE_DEPTH / 2) / SINE_TABLE_DEPTH;
    assign rom[k] = MagW'(ess_sine_entry(X, Peak));
  end

  back_state_e              state_q, state_d;
  ess_job_t                 job_q;
  logic [AddrW-1:0]         ph_q;
  logic [MagW-1:0]          rom_q;
  logic [ESS_LEN_W:0]       rem_q;
  logic [ESS_GAIN_W-1:0]    quo_q;
  logic [ESS_DIV_CNT_W-1:0] cnt_q;
  logic [ESS_GAIN_W-1:0]    g2_q;
  logic [SaW-1:0]           sa_q;
  logic [ProdW-1:0]         prod_q;

  logic                          out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] sample_q, sample_d;
  stage_e                        ostage_q;

  logic                    emit;
  logic                    slot_free;
  logic                    fade;
  logic                    need_div;
  logic [IdxW-1:0]         idx;
  logic [ESS_AMP_W-1:0]    amp_sat;
  logic                    ge;
  logic [ESS_LEN_W:0]      rem_sub;
  logic [2*ESS_GAIN_W-1:0] sq;
  logic [ProdW-1:0]        rnd;
  logic [SAMPLE_WIDTH-1:0] mag;

  assign slot_free = !out_valid_q || out_o.ready;
  assign fade      = (job_q.stage == ST_FADE_IN) || (job_q.stage == ST_FADE_OUT);
  assign need_div  = fade && (job_q.len != '0);
  assign idx       = ph_q[TabW] ? (IdxW'(SINE_TABLE_DEPTH) - {1'b0, ph_q[TabW-1:0]})
                                : {1'b0, ph_q[TabW-1:0]};
  assign amp_sat   = (amplitude_i > ESS_AMP_FULL) ? ESS_AMP_FULL : amplitude_i;

  assign ge      = (rem_q >= {1'b0, job_q.len});
  assign rem_sub = ge ? (rem_q - {1'b0, job_q.len}) : rem_q;
  assign sq      = (2*ESS_GAIN_W)'(quo_q) * (2*ESS_GAIN_W)'(quo_q);

  assign rnd = prod_q + ProdW'(ESS_MAG_ROUND);
  assign mag = rnd[ESS_MAG_SHIFT +: SAMPLE_WIDTH];

  always_comb begin
    if ((job_q.stage == ST_DELAY) || (job_q.stage == ST_FINISHED)) begin
      sample_d = '0;
    end else if (ph_q[AddrW-1]) begin
      sample_d = -$signed(mag);
    end else begin
      sample_d = $signed(mag);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (!q_empty_i) state_d = B_LOOK;
      end
      B_LOOK: state_d = need_div ? B_DIV : B_MAG1;
      B_DIV: begin
        if (cnt_q == ESS_DIV_CNT_W'(1)) state_d = B_SQR;
      end
      B_SQR:  state_d = B_MAG1;
      B_MAG1: state_d = B_MAG2;
      B_MAG2: state_d = B_EMIT;
      B_EMIT: begin
        if (slot_free) state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o = (state_q == B_IDLE) && !q_empty_i;
    emit    = (state_q == B_EMIT) && slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      job_q <= q_job_i;
      ph_q  <= q_phase_i;
    end
    if (state_q == B_LOOK) begin
      rom_q <= rom[idx];
      rem_q <= {1'b0, job_q.num};
      quo_q <= '0;
      cnt_q <= ESS_DIV_CNT_W'(ESS_GAIN_W);
      if (!need_div) g2_q <= ESS_UNITY_GAIN;
    end
    if (state_q == B_DIV) begin
      rem_q <= {rem_sub[ESS_LEN_W-1:0], 1'b0};
      quo_q <= {quo_q[ESS_GAIN_W-2:0], ge};
      cnt_q <= cnt_q - ESS_DIV_CNT_W'(1);
    end
    if (state_q == B_SQR) begin
      g2_q <= sq[ESS_GAIN_FRAC +: ESS_GAIN_W];
    end
    if (state_q == B_MAG1) begin
      sa_q <= SaW'(rom_q) * SaW'(amp_sat);
    end
    if (state_q == B_MAG2) begin
      prod_q <= ProdW'(sa_q) * ProdW'(g2_q);
    end
    if (emit) begin
      sample_q <= sample_d;
      ostage_q <= job_q.stage;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.sample   = sample_q;
  assign out_o.stage    = ostage_q;
  assign out_o.finished = (ostage_q == ST_FINISHED);

endmodule

@@ hdl/exponential_sine_sweep_generator.sv @@
// ----------------------------------------------------------------------------
// Exponential sine sweep generator
// Produces one signed audio sample for every tick item on the input channel.
//
// Each tick item carries a restart flag; each result item carries the sample,
// the stage that made it and a finished flag. Registers are written through
// the plain write port and hold their values until written again.
// The sequencer queues a job for the sample datapath as it takes a tick; in the
// sweep stage it then multiplies and updates the increment before the next tick.
// The datapath looks up the sine and scales it by amplitude and gain; a fade
// sample first runs the 17-step gain divider and the squarer. The datapath
// takes the next job only once it has handed the last sample to the output.
// Reset loads the register defaults, puts the sequence in the delay stage
// with zero phase, empties the job queue and clears the output valid flag.
// While the receiver stalls the output register holds its item, the datapath
// waits, the two-entry queue fills and then the tick channel stops accepting.
// ----------------------------------------------------------------------------
module exponential_sine_sweep_generator import ess_pkg::*; #(
  parameter int unsigned SINE_TABLE_DEPTH = ESS_SINE_TABLE_DEPTH,
  parameter int unsigned SAMPLE_WIDTH     = ESS_SAMPLE_WIDTH,
  parameter int unsigned PHASE_WIDTH      = ESS_PHASE_WIDTH,
  parameter int unsigned QUEUE_DEPTH      = ESS_QUEUE_DEPTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [ESS_CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ESS_CFG_DATA_W-1:0] cfg_wdata_i,
  ess_in_if.sink                    in_i,
  ess_out_if.source                 out_o
);

  localparam int unsigned AddrW = $clog2(SINE_TABLE_DEPTH) + 2;
  localparam int unsigned JobW  = $bits(ess_job_t) + AddrW;

  ess_cfg_t         cfg_q;
  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;
  ess_job_t         push_job;
  logic [AddrW-1:0] push_phase;
  logic [JobW-1:0]  head;
  ess_job_t         head_job;
  logic [AddrW-1:0] head_phase;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= ESS_CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START_INC:    cfg_q.start_inc    <= cfg_wdata_i[ESS_INC_W-1:0];
        CFG_FINAL_INC:    cfg_q.final_inc    <= cfg_wdata_i[ESS_INC_W-1:0];
        CFG_STEP_MUL:     cfg_q.step_mul     <= cfg_wdata_i[ESS_INC_W-1:0];
        CFG_DELAY_LEN:    cfg_q.delay_len    <= cfg_wdata_i[ESS_DLY_W-1:0];
        CFG_FADE_IN_LEN:  cfg_q.fade_in_len  <= cfg_wdata_i[ESS_LEN_W-1:0];
        CFG_FADE_OUT_LEN: cfg_q.fade_out_len <= cfg_wdata_i[ESS_LEN_W-1:0];
        CFG_AMPLITUDE:    cfg_q.amplitude    <= cfg_wdata_i[ESS_AMP_W-1:0];
        default: ;
      endcase
    end
  end

  ess_front #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .PHASE_WIDTH      (PHASE_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .in_i      (in_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_job_o   (push_job),
    .q_phase_o (push_phase)
  );

  ess_queue #(
    .WIDTH (JobW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  ({push_job, push_phase}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (head),
    .empty_o (q_empty)
  );

  assign head_job   = head[JobW-1 -: $bits(ess_job_t)];
  assign head_phase = head[AddrW-1:0];

  ess_back #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .SAMPLE_WIDTH     (SAMPLE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .amplitude_i (cfg_q.amplitude),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .q_job_i     (head_job),
    .q_phase_i   (head_phase),
    .out_o       (out_o)
  );

endmodule
